// ===== rtl/arma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arma_pkg
// Shared types and constants for the ASCII range moving average block.
// ----------------------------------------------------------------------------
package arma_pkg;

    localparam int unsigned DistW = 14;
    localparam int unsigned SumW  = DistW + 1;
    localparam int unsigned ByteW = 8;

    localparam logic [DistW-1:0] MaxDistanceReset = 14'd2500;
    localparam logic [ByteW-1:0] AsciiZero        = 8'h30;
    localparam logic [ByteW-1:0] AsciiNine        = 8'h39;

    // Reciprocal of three for a 15-bit dividend: floor(x * 43691 / 2^17)
    localparam int unsigned      RecipShift = 17;
    localparam logic [15:0]      Recip3     = 16'd43691;

    // Ring of the last three kept samples
    localparam int unsigned      RingDepth  = 3;
    localparam logic [1:0]       RingLast   = 2'd2;
    localparam logic [1:0]       FillFull   = 2'd3;

    typedef logic [DistW-1:0] t_dist;

    // Word handed from the ring stage to the divide stage
    typedef struct packed {
        logic [SumW-1:0] sum;
        t_dist           raw;
    } t_sum_word;

endpackage

// ===== rtl/arma_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arma_parse
// Frame tracker and ASCII decimal parser; registers a kept sample per frame.
// ----------------------------------------------------------------------------
module arma_parse #(
    parameter int unsigned FRAME_BYTES = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_rx_byte,
    input  arma_pkg::t_dist     i_max_distance,
    output logic                o_smp_valid,
    input  logic                i_smp_ready,
    output arma_pkg::t_dist     o_smp
);

    localparam int unsigned PosW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);

    logic [PosW-1:0]  r_pos, n_pos;
    arma_pkg::t_dist  r_digit, n_digit;
    logic             r_stop, n_stop;
    logic             r_smp_valid, n_smp_valid;
    arma_pkg::t_dist  r_smp, n_smp;

    logic             accept;
    logic             is_digit;
    arma_pkg::t_dist  digit_val;
    arma_pkg::t_dist  next_acc;
    logic             keep;

    assign o_ready     = !r_smp_valid || i_smp_ready;
    assign accept      = i_valid && o_ready;
    assign o_smp_valid = r_smp_valid;
    assign o_smp       = r_smp;

    // Decode the byte and form the next accumulator value
    assign is_digit  = (i_rx_byte >= arma_pkg::AsciiZero) && (i_rx_byte <= arma_pkg::AsciiNine);
    assign digit_val = arma_pkg::t_dist'(i_rx_byte - arma_pkg::AsciiZero);
    assign next_acc  = (r_digit << 3) + (r_digit << 1) + digit_val;
    assign keep      = (r_digit != '0) && (r_digit < i_max_distance);

    // Advance the frame, parse digits, close the frame on its last byte
    always_comb begin
        n_pos       = r_pos;
        n_digit     = r_digit;
        n_stop      = r_stop;
        n_smp_valid = r_smp_valid && !i_smp_ready;
        n_smp       = r_smp;
        if (accept) begin
            if (r_pos != LastPos) begin
                if (!r_stop && is_digit) begin
                    n_digit = next_acc;
                end else begin
                    n_stop = 1'b1;
                end
                n_pos = r_pos + 1'b1;
            end else begin
                n_pos   = '0;
                n_digit = '0;
                n_stop  = 1'b0;
                if (keep) begin
                    n_smp_valid = 1'b1;
                    n_smp       = r_digit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_digit     <= '0;
            r_stop      <= 1'b0;
            r_smp_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_digit     <= n_digit;
            r_stop      <= n_stop;
            r_smp_valid <= n_smp_valid;
        end
    end

    // Sample payload, no reset
    always_ff @(posedge i_clk) begin
        r_smp <= n_smp;
    end

endmodule

// ===== rtl/arma_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arma_ring
// Three-entry sample ring with fill count; registers the sum once warm.
// ----------------------------------------------------------------------------
module arma_ring (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_smp_valid,
    output logic                 o_smp_ready,
    input  arma_pkg::t_dist      i_smp,
    output logic                 o_valid,
    input  logic                 i_ready,
    output arma_pkg::t_sum_word  o_word
);

    arma_pkg::t_dist      r_ring [arma_pkg::RingDepth];
    logic [1:0]           r_ptr, n_ptr;
    logic [1:0]           r_fill, n_fill;
    logic                 r_valid, n_valid;
    arma_pkg::t_sum_word  r_word, n_word;

    logic                 accept;
    arma_pkg::t_dist      pick [arma_pkg::RingDepth];

    assign o_smp_ready = !r_valid || i_ready;
    assign accept      = i_smp_valid && o_smp_ready;
    assign o_valid     = r_valid;
    assign o_word      = r_word;

    // Substitute the new sample for the entry it overwrites
    always_comb begin
        for (int i = 0; i < arma_pkg::RingDepth; i++) begin
            pick[i] = (r_ptr == 2'(i)) ? i_smp : r_ring[i];
        end
    end

    // Advance pointer and fill count, emit once three samples are held
    always_comb begin
        n_ptr      = r_ptr;
        n_fill     = r_fill;
        n_valid    = r_valid && !i_ready;
        n_word     = r_word;
        if (accept) begin
            n_ptr  = (r_ptr == arma_pkg::RingLast) ? 2'd0 : r_ptr + 2'd1;
            n_fill = (r_fill == arma_pkg::FillFull) ? r_fill : r_fill + 2'd1;
            if (n_fill == arma_pkg::FillFull) begin
                n_valid    = 1'b1;
                n_word.sum = arma_pkg::SumW'(pick[0]) + arma_pkg::SumW'(pick[1])
                           + arma_pkg::SumW'(pick[2]);
                n_word.raw = i_smp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_ptr   <= n_ptr;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
    end

    // Ring entries and sum payload, no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (accept) begin
            r_ring[r_ptr] <= i_smp;
        end
    end

endmodule

// ===== rtl/arma_div3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arma_div3
// Divides the ring sum by three with a reciprocal multiply; output register.
// ----------------------------------------------------------------------------
module arma_div3 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  arma_pkg::t_sum_word  i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output arma_pkg::t_dist      o_mean,
    output arma_pkg::t_dist      o_raw
);

    logic             r_valid;
    arma_pkg::t_dist  r_mean;
    arma_pkg::t_dist  r_raw;
    logic [31:0]      prod;
    logic             accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_mean  = r_mean;
    assign o_raw   = r_raw;

    // Exact floor(sum / 3) for any sum below 2^17
    assign prod = 32'(i_word.sum) * 32'(arma_pkg::Recip3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mean <= prod[arma_pkg::RecipShift +: arma_pkg::DistW];
            r_raw  <= i_word.raw;
        end
    end

endmodule

// ===== rtl/ascii_range_moving_average.sv =====
`timescale 1ns / 1ps
// Throughput: one byte word per clock cycle; each pipeline stage holds a word while stalled.
// Path: the last byte of a frame passes through the parse register, the ring/sum register
//   and the divide/output register, in that order, before the result is shown.
// Bytes other than the last of a frame, and dropped frames, produce no result.
// Reset (i_rst_n, synchronous, active low) clears frame position, parser, ring pointer,
//   fill count and all valid flags, and sets max_distance to 2500.
// ----------------------------------------------------------------------------
// ascii_range_moving_average
// Parses ASCII distance frames and emits a three-sample moving average.
// ----------------------------------------------------------------------------
module ascii_range_moving_average #(
    parameter int unsigned FRAME_BYTES = 5
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [7:0]   i_rx_byte,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [13:0]  o_mean_distance,
    output logic [13:0]  o_raw_distance,
    input  logic         i_cfg_we,
    input  logic [13:0]  i_cfg_wdata
);

    arma_pkg::t_dist      r_max_distance;
    logic                 smp_valid;
    logic                 smp_ready;
    arma_pkg::t_dist      smp;
    logic                 sum_valid;
    logic                 sum_ready;
    arma_pkg::t_sum_word  sum_word;

    // Hold the distance limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_distance <= arma_pkg::MaxDistanceReset;
        end else if (i_cfg_we) begin
            r_max_distance <= i_cfg_wdata;
        end
    end

    arma_parse #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .i_max_distance (r_max_distance),
        .o_smp_valid    (smp_valid),
        .i_smp_ready    (smp_ready),
        .o_smp          (smp)
    );

    arma_ring u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp_valid (smp_valid),
        .o_smp_ready (smp_ready),
        .i_smp       (smp),
        .o_valid     (sum_valid),
        .i_ready     (sum_ready),
        .o_word      (sum_word)
    );

    arma_div3 u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .o_ready (sum_ready),
        .i_word  (sum_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_mean  (o_mean_distance),
        .o_raw   (o_raw_distance)
    );

endmodule

// ===== rtl/arma_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arma_checker
// Port-level checks on the result channel of the moving average block.
// ----------------------------------------------------------------------------
module arma_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         o_valid,
    input  logic         i_ready,
    input  logic [13:0]  o_mean_distance,
    input  logic [13:0]  o_raw_distance
);

    // Drop any result during and right after reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Hold a stalled result word
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mean_distance)
                               && $stable(o_raw_distance))
        else $error("stalled result changed");

    // A kept sample is never zero
    a_raw_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_raw_distance != 14'd0)
        else $error("zero raw distance emitted");

    // Three samples of at least one average to at least one
    a_mean_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_mean_distance != 14'd0)
        else $error("zero mean emitted");

endmodule

bind ascii_range_moving_average arma_checker u_arma_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_mean_distance (o_mean_distance),
    .o_raw_distance  (o_raw_distance)
);
